>>> rtl/core/point_pair_distance_gradient_macros.svh
// ----------------------------------------------------------------------------
// point pair distance gradient assertion macros
// concurrent assertion helpers shared by the rtl files of the block
// ----------------------------------------------------------------------------
`ifndef POINT_PAIR_DISTANCE_GRADIENT_MACROS_SVH
`define POINT_PAIR_DISTANCE_GRADIENT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define PPDG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define PPDG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PPDG_ASSERT(lbl, clk, rst_n, prop, msg)

`define PPDG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/core/ppdg_pkg.sv
// ----------------------------------------------------------------------------
// ppdg_pkg
// types, constants and helpers of the point pair distance gradient block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppdg_pkg;

  localparam int unsigned DATA_W    = 32;               // field width
  localparam int unsigned DIFF_W    = DATA_W + 1;       // exact a - b
  localparam int unsigned PROD_W    = 2 * DATA_W;       // one magnitude product
  localparam int unsigned ACC_W     = PROD_W + 3;       // signed sum of three products
  localparam int unsigned NUM_W     = ACC_W - 1;        // magnitude of the sum
  localparam int unsigned DIST_W    = DATA_W - 1;       // distance never sets the sign bit
  localparam int unsigned QUO_W     = DATA_W + 1;       // quotient with one guard bit
  localparam int unsigned REM_W     = DATA_W;           // partial remainder
  localparam int unsigned TRIAL_W   = DATA_W + 2;       // trial subtract width
  localparam int unsigned STEP_W    = 7;
  localparam int unsigned SQRT_BITS = 2 * DIST_W;       // radicand bits
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(DIST_W);
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(NUM_W);

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    ACT_PAIR   = 1'b0,
    ACT_COLUMN = 1'b1
  } ppdg_action_e;

  typedef enum logic {
    KIND_DIST = 1'b0,
    KIND_GRAD = 1'b1
  } ppdg_kind_e;

  typedef enum logic {
    MODE_SQRT = 1'b0,
    MODE_DIV  = 1'b1
  } ppdg_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_WAIT,
    ST_DONE
  } ppdg_state_e;

  typedef struct packed {
    logic       start;
    ppdg_mode_e mode;
  } ppdg_unit_ctrl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } ppdg_unit_stat_t;

  // magnitude of an exact difference, which never reaches 2^32
  function automatic logic [DATA_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] t;
    t = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
    return t[DATA_W-1:0];
  endfunction

endpackage

>>> rtl/core/ppdg_if.sv
// ----------------------------------------------------------------------------
// ppdg channel interfaces
// valid / ready channels for input words and result words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppdg_in_if;
  import ppdg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] value_a_x;
  logic signed [DATA_W-1:0] value_a_y;
  logic signed [DATA_W-1:0] value_a_z;
  logic signed [DATA_W-1:0] value_b_x;
  logic signed [DATA_W-1:0] value_b_y;
  logic signed [DATA_W-1:0] value_b_z;

  modport source (
    output valid, action, value_a_x, value_a_y, value_a_z,
           value_b_x, value_b_y, value_b_z,
    input  ready
  );

  modport sink (
    input  valid, action, value_a_x, value_a_y, value_a_z,
           value_b_x, value_b_y, value_b_z,
    output ready
  );
endinterface

interface ppdg_out_if;
  import ppdg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     result_kind;
  logic                     saturated;

  modport source (
    output valid, result_value, result_kind, saturated,
    input  ready
  );

  modport sink (
    input  valid, result_value, result_kind, saturated,
    output ready
  );
endinterface

>>> rtl/core/ppdg_root_div.sv
// ----------------------------------------------------------------------------
// ppdg_root_div
// shared restoring unit: integer square root or long division, one digit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_pair_distance_gradient_macros.svh"

module ppdg_root_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ppdg_pkg::ppdg_unit_ctrl_t        ctrl_i,
  input  logic [ppdg_pkg::NUM_W-1:0]       operand_i,
  input  logic [ppdg_pkg::DIST_W-1:0]      divisor_i,
  output ppdg_pkg::ppdg_unit_stat_t        stat_o,
  output logic [ppdg_pkg::QUO_W-1:0]       quot_o
);
  import ppdg_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  ppdg_mode_e        mode_q;

  logic [NUM_W-1:0]  num_q;
  logic [DIST_W-1:0] div_q;
  logic [REM_W-1:0]  rem_q;
  logic [QUO_W-1:0]  q_q;
  logic              ovf_q;

  logic [TRIAL_W-1:0] part_w;
  logic [TRIAL_W-1:0] trial_w;
  logic [TRIAL_W:0]   diff_w;
  logic               ge_w;
  logic [REM_W-1:0]   rem_bound_w;

  // sqrt brings down two radicand bits against 4*root+1, division one bit against d
  always_comb begin
    if (mode_q == MODE_SQRT) begin
      part_w  = {rem_q, num_q[NUM_W-1 -: 2]};
      trial_w = {q_q[DATA_W-1:0], 2'b01};
    end else begin
      part_w  = {1'b0, rem_q, num_q[NUM_W-1]};
      trial_w = {{(TRIAL_W-DIST_W){1'b0}}, div_q};
    end
    diff_w      = {1'b0, part_w} - {1'b0, trial_w};
    ge_w        = ~diff_w[TRIAL_W];
    rem_bound_w = {q_q[DIST_W-1:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= MODE_SQRT;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_W'(1));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        mode_q <= ctrl_i.mode;
        cnt_q  <= (ctrl_i.mode == MODE_SQRT) ? SQRT_STEPS : DIV_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      num_q <= operand_i;
      div_q <= divisor_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= (mode_q == MODE_SQRT) ? {num_q[NUM_W-3:0], 2'b00} : {num_q[NUM_W-2:0], 1'b0};
      rem_q <= ge_w ? diff_w[REM_W-1:0] : part_w[REM_W-1:0];
      q_q   <= {q_q[QUO_W-2:0], ge_w};
      // a quotient bit pushed past the guard bit means far out of range
      ovf_q <= ovf_q | q_q[QUO_W-1];
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign quot_o      = q_q;

  `PPDG_ASSERT(a_start_when_free, clk_i, rst_ni, ctrl_i.start |-> !busy_q, "unit started while busy")
  `PPDG_ASSERT_NEVER(a_busy_has_steps, clk_i, rst_ni, busy_q && (cnt_q == '0), "busy with no steps left")
  `PPDG_ASSERT(a_root_rem_bound, clk_i, rst_ni, (busy_q && (mode_q == MODE_SQRT)) |-> (rem_q <= rem_bound_w), "sqrt remainder above twice the root")

endmodule

>>> rtl/core/point_pair_distance_gradient.sv
// ----------------------------------------------------------------------------
// point_pair_distance_gradient
// euclidean distance between two 3-d points and its gradient per jacobian column
// ----------------------------------------------------------------------------
// A pair word (action 0) carries points A and B; the block keeps d = A - B
// exactly and returns floor(sqrt(dx^2 + dy^2 + dz^2)), clipped to 2^31-1 with
// saturated set. A column word (action 1) carries JA and JB for one joint and
// returns trunc((d . (JA - JB)) / |d|) clipped to the signed 32-bit range, or
// zero when gradient_enable is low or the stored distance is zero. The math is
// on raw integers, so the result is the same for any number of fraction bits
// (Q16.16 in normal use). Every word gives exactly one result word. In order:
// the word is taken, three passes go through the single 32x32 multiplier and
// accumulator (three products), a setup step starts the shared restoring
// root/divide unit at one digit a cycle: 31 steps for a distance, 66 steps
// for a gradient entry; then the result goes to the output register. A column
// that is answered with zero skips the multiplier and the unit. The input is
// not ready while a word is in work, but a new word is taken while the
// previous result still sits in the output register. gradient_enable resets
// to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_pair_distance_gradient_macros.svh"

module point_pair_distance_gradient (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  ppdg_in_if.sink      in_i,
  ppdg_out_if.source   out_o
);
  import ppdg_pkg::*;

  // sequencer
  ppdg_state_e state_q, state_d;
  logic [1:0]  cnt_q;
  logic        in_fire;
  logic        out_free;

  // configuration
  logic grad_en_q;

  // stored pair state and the current column
  logic signed [DIFF_W-1:0] diff_x_q, diff_y_q, diff_z_q;
  logic signed [DIFF_W-1:0] jv_x_q, jv_y_q, jv_z_q;
  logic [DIST_W-1:0]        pair_dist_q;
  ppdg_action_e             action_q;

  // multiply / accumulate
  logic signed [DIFF_W-1:0] sel_d_w, sel_j_w;
  logic [DATA_W-1:0]        mag_a_w, mag_b_w;
  logic [PROD_W-1:0]        prod_w;
  logic [PROD_W-1:0]        prod_q;
  logic                     prod_neg_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     acc_neg_q;
  logic [ACC_W-1:0]         acc_mag_w;
  logic                     dist_sat_w;

  // root / divide unit
  ppdg_unit_ctrl_t    unit_ctrl;
  ppdg_unit_stat_t    unit_stat;
  logic [NUM_W-1:0]   unit_operand;
  logic [QUO_W-1:0]   unit_quot;

  // gradient clip
  logic              quot_big_w;
  logic              grad_sat_w;
  logic [DATA_W-1:0] grad_val_w;

  // pending result and output register
  logic [DATA_W-1:0] res_value_q;
  ppdg_kind_e        res_kind_q;
  logic              res_sat_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  ppdg_kind_e        out_kind_q;
  logic              out_sat_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // operand select for the shared multiplier, one axis per pass
  always_comb begin
    case (cnt_q)
      2'd0:    begin sel_d_w = diff_x_q; sel_j_w = jv_x_q; end
      2'd1:    begin sel_d_w = diff_y_q; sel_j_w = jv_y_q; end
      default: begin sel_d_w = diff_z_q; sel_j_w = jv_z_q; end
    endcase
  end

  assign mag_a_w = mag_diff(sel_d_w);
  assign mag_b_w = (action_q == ACT_COLUMN) ? mag_diff(sel_j_w) : mag_a_w;
  assign prod_w  = PROD_W'(mag_a_w) * PROD_W'(mag_b_w);

  // sum of squares is never negative; at or above 2^62 the root passes 2^31-1
  assign dist_sat_w = |acc_q[ACC_W-1:SQRT_BITS];
  assign acc_mag_w  = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;

  // quotient clip: the guard and overflow bits flag anything at or past 2^32
  always_comb begin
    quot_big_w = unit_stat.ovf | unit_quot[QUO_W-1];
    if (acc_neg_q) begin
      grad_sat_w = quot_big_w | (unit_quot[DATA_W-1] & (|unit_quot[DATA_W-2:0]));
      grad_val_w = grad_sat_w ? SAT_NEG : (~unit_quot[DATA_W-1:0] + DATA_W'(1));
    end else begin
      grad_sat_w = quot_big_w | unit_quot[DATA_W-1];
      grad_val_w = grad_sat_w ? SAT_POS : unit_quot[DATA_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_i.action == ACT_COLUMN) && (!grad_en_q || (pair_dist_q == '0))) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = (cnt_q == 2'd2) ? ST_FIN : ST_MUL;
      ST_FIN: begin
        if ((action_q == ACT_PAIR) && dist_sat_w) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (unit_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready      = (state_q == ST_IDLE);
    unit_ctrl.start = 1'b0;
    unit_ctrl.mode  = MODE_SQRT;
    unit_operand    = {acc_q[SQRT_BITS-1:0], {(NUM_W-SQRT_BITS){1'b0}}};
    unique case (state_q)
      ST_FIN: begin
        if (action_q == ACT_PAIR) begin
          unit_ctrl.start = !dist_sat_w;
        end else begin
          unit_ctrl.start = 1'b1;
          unit_ctrl.mode  = MODE_DIV;
          unit_operand    = acc_mag_w[NUM_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  ppdg_root_div u_root_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (unit_ctrl),
    .operand_i (unit_operand),
    .divisor_i (pair_dist_q),
    .stat_o    (unit_stat),
    .quot_o    (unit_quot)
  );

  // control state, stored pair state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      grad_en_q   <= 1'b1;
      diff_x_q    <= '0;
      diff_y_q    <= '0;
      diff_z_q    <= '0;
      pair_dist_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        grad_en_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        cnt_q <= '0;
        if (in_i.action == ACT_PAIR) begin
          diff_x_q <= DIFF_W'(in_i.value_a_x) - DIFF_W'(in_i.value_b_x);
          diff_y_q <= DIFF_W'(in_i.value_a_y) - DIFF_W'(in_i.value_b_y);
          diff_z_q <= DIFF_W'(in_i.value_a_z) - DIFF_W'(in_i.value_b_z);
        end
      end else if (state_q == ST_ACC) begin
        cnt_q <= cnt_q + 2'd1;
      end
      // the stored distance is the clipped one
      if ((state_q == ST_FIN) && (action_q == ACT_PAIR) && dist_sat_w) begin
        pair_dist_q <= SAT_POS[DIST_W-1:0];
      end else if ((state_q == ST_WAIT) && unit_stat.done && (action_q == ACT_PAIR)) begin
        pair_dist_q <= unit_quot[DIST_W-1:0];
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= ppdg_action_e'(in_i.action);
      acc_q    <= '0;
      // column answered at once with zero when disabled or distance is zero
      res_value_q <= '0;
      res_kind_q  <= KIND_GRAD;
      res_sat_q   <= 1'b0;
      if (in_i.action == ACT_COLUMN) begin
        jv_x_q <= DIFF_W'(in_i.value_a_x) - DIFF_W'(in_i.value_b_x);
        jv_y_q <= DIFF_W'(in_i.value_a_y) - DIFF_W'(in_i.value_b_y);
        jv_z_q <= DIFF_W'(in_i.value_a_z) - DIFF_W'(in_i.value_b_z);
      end
    end
    if (state_q == ST_MUL) begin
      prod_q     <= prod_w;
      prod_neg_q <= (action_q == ACT_COLUMN) && (sel_d_w[DIFF_W-1] != sel_j_w[DIFF_W-1]);
    end
    if (state_q == ST_ACC) begin
      acc_q <= prod_neg_q ? (acc_q - $signed(ACC_W'(prod_q)))
                          : (acc_q + $signed(ACC_W'(prod_q)));
    end
    if (state_q == ST_FIN) begin
      acc_neg_q <= acc_q[ACC_W-1];
      if ((action_q == ACT_PAIR) && dist_sat_w) begin
        res_value_q <= SAT_POS;
        res_kind_q  <= KIND_DIST;
        res_sat_q   <= 1'b1;
      end
    end
    if ((state_q == ST_WAIT) && unit_stat.done) begin
      if (action_q == ACT_PAIR) begin
        res_value_q <= {1'b0, unit_quot[DIST_W-1:0]};
        res_kind_q  <= KIND_DIST;
        res_sat_q   <= 1'b0;
      end else begin
        res_value_q <= grad_val_w;
        res_kind_q  <= KIND_GRAD;
        res_sat_q   <= grad_sat_w;
      end
    end
    // output word register, loaded when empty or being taken
    if ((state_q == ST_DONE) && out_free) begin
      out_value_q <= res_value_q;
      out_kind_q  <= res_kind_q;
      out_sat_q   <= res_sat_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_value_q;
  assign out_o.result_kind  = out_kind_q;
  assign out_o.saturated    = out_sat_q;

  `PPDG_ASSERT(a_column_keeps_dist, clk_i, rst_ni, (in_fire && (in_i.action == ACT_COLUMN)) |=> $stable(pair_dist_q), "column word changed the stored distance")
  `PPDG_ASSERT_NEVER(a_dist_nonneg, clk_i, rst_ni, out_o.valid && (out_o.result_kind == KIND_DIST) && out_o.result_value[DATA_W-1], "negative distance word")
  `PPDG_ASSERT(a_dist_sat_max, clk_i, rst_ni, (out_o.valid && (out_o.result_kind == KIND_DIST) && out_o.saturated) |-> (out_o.result_value == SAT_POS), "clipped distance is not the maximum")

endmodule

>>> tb/sv/point_pair_distance_gradient_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point pair distance gradient testbench
// drives pair and column words through the valid / ready channels, predicts
// every distance and gradient word from a local copy of the stored difference
// and distance, and checks each result word in order; a directed table comes
// first, then random phases under different gradient_enable settings
// ----------------------------------------------------------------------------
module point_pair_distance_gradient_test;
  import ppdg_pkg::*;

  // run shape
  localparam int unsigned PHASES          = 8;
  localparam int unsigned WORDS_PER_PHASE = 50;
  localparam int unsigned HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES   = 90;    // idle tail after the last result word
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned PRINT_CAP       = 200;

  localparam logic signed [DATA_W-1:0] MAX_RAW = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_RAW = 32'sh8000_0000;

  // one result word
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    ppdg_kind_e               kind;
    logic                     sat;
  } result_t;

  // one stimulus word, with an optional register write ahead of it and an
  // optional hand-written result
  typedef struct packed {
    bit                       cfg_write;
    bit                       cfg_value;
    bit                       typed;
    ppdg_action_e             action;
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
    result_t                  want;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  ppdg_in_if  word_in ();
  ppdg_out_if word_out ();

  point_pair_distance_gradient u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (word_in),
    .out_o       (word_out)
  );

  always #1 clk_i = ~clk_i;

  // local copy of the block state, updated as words are accepted
  logic signed [DIFF_W-1:0] held_dx, held_dy, held_dz;
  logic [DATA_W-1:0]        held_distance;
  bit                       grad_on;

  result_t     answers_due [$];   // predicted result words, oldest first
  stim_t       directed_rows [$];
  int unsigned mismatch_count = 0;

  // handshake pacing shared by sender and receiver
  bit quiet        = 1'b0;   // no idling at all while set
  bit hold_request = 1'b0;   // receiver holds off for HOLD_CYCLES

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  // distance word: floor of the root of the exact sum of squares, clipped to
  // 2^31-1 once the sum reaches 2^62; stored for the column words after it.
  // column word: exact dot product of the stored difference with ja - jb,
  // divided by the stored distance, truncated toward zero and clipped to the
  // signed range; zero when disabled or when no distance is held
  function automatic result_t compute_answer(stim_t s);
    logic signed [67:0] ex, ey, ez, jx, jy, jz, acc;
    logic [67:0]        mag, quo;
    logic [63:0]        root, trial;
    result_t            r;
    r.sat   = 1'b0;
    r.value = '0;
    if (s.action == ACT_PAIR) begin
      r.kind  = KIND_DIST;
      held_dx = $signed(s.a_x) - $signed(s.b_x);
      held_dy = $signed(s.a_y) - $signed(s.b_y);
      held_dz = $signed(s.a_z) - $signed(s.b_z);
      ex = held_dx;
      ey = held_dy;
      ez = held_dz;
      acc = ex * ex + ey * ey + ez * ez;
      if (acc[67:62] != 0) begin
        r.value = SAT_POS;
        r.sat   = 1'b1;
      end else begin
        // bit-by-bit floor root, the answer fits in 31 bits
        root = '0;
        for (int b = 30; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= acc[63:0]) root = trial;
        end
        r.value = root[DATA_W-1:0];
      end
      held_distance = r.value;
    end else begin
      r.kind = KIND_GRAD;
      if (grad_on && held_distance != 0) begin
        ex = held_dx;
        ey = held_dy;
        ez = held_dz;
        jx = $signed(s.a_x) - $signed(s.b_x);
        jy = $signed(s.a_y) - $signed(s.b_y);
        jz = $signed(s.a_z) - $signed(s.b_z);
        acc = ex * jx + ey * jy + ez * jz;
        mag = acc[67] ? -acc : acc;
        quo = mag / {36'd0, held_distance};
        if (acc[67]) begin
          // -2^31 itself is reachable without clipping
          if (quo > 68'h8000_0000) begin
            r.value = SAT_NEG;
            r.sat   = 1'b1;
          end else begin
            r.value = -quo[DATA_W-1:0];
          end
        end else if (quo > 68'h7FFF_FFFF) begin
          r.value = SAT_POS;
          r.sat   = 1'b1;
        end else begin
          r.value = quo[DATA_W-1:0];
        end
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  function automatic stim_t row(ppdg_action_e act,
                                logic signed [DATA_W-1:0] ax, ay, az, bx, by, bz);
    stim_t s;
    s        = '0;
    s.action = act;
    s.a_x    = ax;
    s.a_y    = ay;
    s.a_z    = az;
    s.b_x    = bx;
    s.b_y    = by;
    s.b_z    = bz;
    return s;
  endfunction

  function automatic stim_t row_typed(ppdg_action_e act,
                                      logic signed [DATA_W-1:0] ax, ay, az, bx, by, bz,
                                      logic [DATA_W-1:0] value, ppdg_kind_e kind,
                                      logic sat);
    stim_t s;
    s            = row(act, ax, ay, az, bx, by, bz);
    s.typed      = 1'b1;
    s.want.value = value;
    s.want.kind  = kind;
    s.want.sat   = sat;
    return s;
  endfunction

  function automatic stim_t with_cfg(stim_t s, bit en);
    s.cfg_write = 1'b1;
    s.cfg_value = en;
    return s;
  endfunction

  // extremes, unit steps, full-range noise, and mostly values within +/-2^23
  function automatic logic signed [DATA_W-1:0] rand_coord();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = MAX_RAW;
          1:       v = MIN_RAW;
          2:       v = '0;
          3:       v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      1, 2, 3: v = $urandom;
      default: v = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
    return v;
  endfunction

  function automatic stim_t rand_word(ppdg_action_e act);
    return row(act, rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord());
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ------------------------------------------------------------------------
  // sender side, always entered and left at a rising edge
  // ------------------------------------------------------------------------

  // offer one word, wait for the handshake, then queue what it should give;
  // valid stays high on return so a back-to-back word needs no second write
  task automatic send_word(stim_t s);
    int unsigned gap;
    result_t     due;
    gap = idle_len();
    if (gap != 0) begin
      word_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_in.valid     <= 1'b1;
    word_in.action    <= s.action;
    word_in.value_a_x <= s.a_x;
    word_in.value_a_y <= s.a_y;
    word_in.value_a_z <= s.a_z;
    word_in.value_b_x <= s.b_x;
    word_in.value_b_y <= s.b_y;
    word_in.value_b_z <= s.b_z;
    do @(posedge clk_i); while (!word_in.ready);
    due = compute_answer(s);
    if (s.typed) due = s.want;
    answers_due.push_back(due);
  endtask

  // stop offering, let every due word come out, then let the block go quiet
  task automatic drain_answers();
    word_in.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_gradient_enable(bit en);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    grad_on   = en;
  endtask

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t ns: %s differs, expected %h got %h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && word_out.valid && word_out.ready) begin
      if (answers_due.size() == 0) begin
        flag_mismatch("unexpected result word", '0, word_out.result_value);
      end else begin
        want = answers_due.pop_front();
        if (word_out.result_value !== want.value)
          flag_mismatch("result_value", want.value, word_out.result_value);
        if (word_out.result_kind !== want.kind)
          flag_mismatch("result_kind", want.kind, word_out.result_kind);
        if (word_out.saturated !== want.sat)
          flag_mismatch("saturated", want.sat, word_out.saturated);
      end
    end
  end

  // ------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off on request
  // ------------------------------------------------------------------------

  initial begin : result_receiver
    int unsigned stall_left;
    stall_left     = 0;
    word_out.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        // block fills up while the sender keeps offering
        word_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
        stall_left   = 0;
      end else if (stall_left != 0) begin
        word_out.ready <= 1'b0;
        stall_left--;
      end else begin
        word_out.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = idle_len();
      end
    end
  end

  // ------------------------------------------------------------------------
  // watchdog: too long with no word moving on either channel
  // ------------------------------------------------------------------------

  initial begin : watchdog
    int unsigned still_cycles;
    still_cycles = 0;
    while (still_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready))
        still_cycles = 0;
      else
        still_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned pick, n, sent;
    stim_t       w;

    // every block input known from time zero
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    word_in.valid     <= 1'b0;
    word_in.action    <= ACT_PAIR;
    word_in.value_a_x <= '0;
    word_in.value_a_y <= '0;
    word_in.value_a_z <= '0;
    word_in.value_b_x <= '0;
    word_in.value_b_y <= '0;
    word_in.value_b_z <= '0;

    // reset state of the local copy
    grad_on       = 1'b1;
    held_dx       = '0;
    held_dy       = '0;
    held_dz       = '0;
    held_distance = '0;

    // directed table, enable at its reset value of 1
    // column before any pair: no distance held yet
    directed_rows.push_back(row_typed(ACT_COLUMN, MAX_RAW, MAX_RAW, MAX_RAW,
                                      MIN_RAW, MIN_RAW, MIN_RAW, '0, KIND_GRAD, 1'b0));
    // coincident points give distance zero, and the column after it zero
    directed_rows.push_back(row_typed(ACT_PAIR, '0, '0, '0, '0, '0, '0,
                                      '0, KIND_DIST, 1'b0));
    directed_rows.push_back(row_typed(ACT_COLUMN, MAX_RAW, '0, '0, '0, '0, '0,
                                      '0, KIND_GRAD, 1'b0));
    // 3-4-5 triangle in q16.16
    directed_rows.push_back(row_typed(ACT_PAIR, 32'sd196608, 32'sd262144, '0, '0, '0, '0,
                                      32'd327680, KIND_DIST, 1'b0));
    directed_rows.push_back(row(ACT_COLUMN, 32'sd65536, '0, '0, '0, '0, '0));
    directed_rows.push_back(row(ACT_COLUMN, '0, -32'sd65536, '0, '0, '0, '0));
    // column with no motion
    directed_rows.push_back(row_typed(ACT_COLUMN, 32'sd5, 32'sd7, -32'sd9,
                                      32'sd5, 32'sd7, -32'sd9, '0, KIND_GRAD, 1'b0));
    // widest separation clips the distance, then both gradient signs clip
    directed_rows.push_back(row_typed(ACT_PAIR, MAX_RAW, MAX_RAW, MAX_RAW,
                                      MIN_RAW, MIN_RAW, MIN_RAW, SAT_POS, KIND_DIST, 1'b1));
    directed_rows.push_back(row_typed(ACT_COLUMN, MAX_RAW, MAX_RAW, MAX_RAW,
                                      MIN_RAW, MIN_RAW, MIN_RAW, SAT_POS, KIND_GRAD, 1'b1));
    directed_rows.push_back(row_typed(ACT_COLUMN, MIN_RAW, MIN_RAW, MIN_RAW,
                                      MAX_RAW, MAX_RAW, MAX_RAW, SAT_NEG, KIND_GRAD, 1'b1));
    directed_rows.push_back(row_typed(ACT_PAIR, MIN_RAW, MIN_RAW, MIN_RAW,
                                      MAX_RAW, MAX_RAW, MAX_RAW, SAT_POS, KIND_DIST, 1'b1));
    directed_rows.push_back(row_typed(ACT_COLUMN, MAX_RAW, MAX_RAW, MAX_RAW,
                                      MIN_RAW, MIN_RAW, MIN_RAW, SAT_NEG, KIND_GRAD, 1'b1));
    // largest distance that does not clip, and the smallest one that does
    directed_rows.push_back(row_typed(ACT_PAIR, MAX_RAW, '0, '0, '0, '0, '0,
                                      SAT_POS, KIND_DIST, 1'b0));
    directed_rows.push_back(row_typed(ACT_PAIR, '0, '0, '0, MIN_RAW, '0, '0,
                                      SAT_POS, KIND_DIST, 1'b1));
    // one lsb of distance, gradient is then the raw dot product
    directed_rows.push_back(row_typed(ACT_PAIR, 32'sd1, '0, '0, '0, '0, '0,
                                      32'd1, KIND_DIST, 1'b0));
    directed_rows.push_back(row_typed(ACT_COLUMN, MAX_RAW, '0, '0, MIN_RAW, '0, '0,
                                      SAT_POS, KIND_GRAD, 1'b1));
    directed_rows.push_back(row_typed(ACT_COLUMN, -32'sd1, '0, '0, '0, '0, '0,
                                      32'hFFFF_FFFF, KIND_GRAD, 1'b0));
    // both ends of the signed range reached exactly, without clipping
    directed_rows.push_back(row_typed(ACT_COLUMN, MIN_RAW, '0, '0, '0, '0, '0,
                                      SAT_NEG, KIND_GRAD, 1'b0));
    directed_rows.push_back(row_typed(ACT_COLUMN, MAX_RAW, '0, '0, '0, '0, '0,
                                      SAT_POS, KIND_GRAD, 1'b0));
    // ordinary values on every axis
    directed_rows.push_back(row(ACT_PAIR, 32'sh1234_5678, -32'sd5, 32'sd77,
                                -32'sh0ABC_DEF0, 32'sd100, '0));
    directed_rows.push_back(row(ACT_COLUMN, 32'sh0001_8000, -32'sh0002_0000, 32'sh7FFF,
                                32'sh100, '0, -32'sh4000));
    // gradient disabled: zero even for a huge column, pairs unaffected
    directed_rows.push_back(with_cfg(row_typed(ACT_COLUMN, MAX_RAW, MAX_RAW, MAX_RAW,
                                               MIN_RAW, MIN_RAW, MIN_RAW,
                                               '0, KIND_GRAD, 1'b0), 1'b0));
    directed_rows.push_back(row(ACT_PAIR, -32'sd196608, '0, 32'sd262144, '0, '0, '0));
    directed_rows.push_back(with_cfg(row(ACT_COLUMN, 32'sd65536, 32'sd65536, 32'sd65536,
                                         '0, '0, '0), 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_write) begin
        drain_answers();
        set_gradient_enable(directed_rows[i].cfg_value);
      end
      send_word(directed_rows[i]);
    end

    // random phases; each starts from an idle block with a fresh enable
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_answers();
      set_gradient_enable(phase % 3 != 2);
      quiet = (phase == 4);
      if (phase == 1) hold_request = 1'b1;
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // usual use: one pair, then one column per joint
          send_word(rand_word(ACT_PAIR));
          n = $urandom_range(1, 6);
          repeat (n) send_word(rand_word(ACT_COLUMN));
          sent += n + 1;
        end else if (pick == 7) begin
          // stray column against whatever pair is held
          send_word(rand_word(ACT_COLUMN));
          sent += 1;
        end else if (pick == 8) begin
          // coincident points, columns must answer zero
          w     = rand_word(ACT_PAIR);
          w.b_x = w.a_x;
          w.b_y = w.a_y;
          w.b_z = w.a_z;
          send_word(w);
          n = $urandom_range(1, 3);
          repeat (n) send_word(rand_word(ACT_COLUMN));
          sent += n + 1;
        end else begin
          // pair replaced before any column uses it
          send_word(rand_word(ACT_PAIR));
          send_word(rand_word(ACT_PAIR));
          send_word(rand_word(ACT_COLUMN));
          sent += 3;
        end
      end
    end

    // everything out, then a quiet tail to catch stray words
    drain_answers();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
